// ----- sv/skg_pkg.sv -----
// Shared constants, types and the CORDIC angle table for the sinc kernel generator.
// No dependencies.
package skg_pkg;

   localparam int MAX_TAPS     = 64;
   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 24;
   localparam int TAP_W        = 6;
   localparam int SIZE_W       = 7;
   localparam int FRAC_W       = FRAC_BITS + 1;
   localparam int COEF_W       = 18;
   localparam int XR_W         = FRAC_BITS + 8;
   localparam int STEP_W       = 5;
   localparam int CW           = 34;
   localparam int DEN_W        = 40;
   localparam int NUM_W        = 48;
   localparam int QCNT_W       = 6;

   localparam logic [31:0] PI_Q30          = 32'd3373259426;
   localparam logic [CW-1:0] CORDIC_GAIN   = CW'(652032874);
   localparam logic [FRAC_W-1:0] ONE       = FRAC_W'(1) << FRAC_BITS;
   localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(65536);
   localparam logic [NUM_W-1:0] COEF_MAX   = NUM_W'(131071);

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // capture fraction and size
      logic tap_setup;  // form x for current tap
      logic cordic_step;
      logic den_mult;
      logic div_init;
      logic div_step;
      logic finish;     // form coefficient into output register
      logic next_tap;
   } skg_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic size_zero;
      logic special;    // x zero or integer: no sine needed
      logic last;
      logic cordic_done;
      logic div_done;
   } skg_sts_type;

   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] k);
      logic [31:0] r;
      unique case (k)
         5'd0:  r = 32'd536870912;  5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;  5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;   5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;   5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;    5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
         5'd20: r = 32'd652;        5'd21: r = 32'd326;
         5'd22: r = 32'd163;        5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/sinc_kernel_generator_unit.sv -----
// Per tap: setup, 24 CORDIC rotations, multiply, divider init, 48 divider bits, finish;
// at an integer position the sine, multiply and division are skipped.
// One request at a time; each tap result is held until rsp_ready is seen,
// and a request yields up to 64 taps.
// Reset: synchronous; tap count returns to 16, controller to idle.
module sinc_kernel_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_tap_count,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [16:0] req_fraction,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [17:0] rsp_coefficient,
   output logic [5:0]  rsp_tap_index,
   output logic        rsp_last_tap
);

   skg_pkg::skg_cmd_type cmd;
   skg_pkg::skg_sts_type sts;
   logic [skg_pkg::SIZE_W-1:0] size_ff;

   // Hold configuration register
   always_ff @(posedge clock) begin
      if (reset) size_ff <= skg_pkg::SIZE_W'(16);
      else if (csr_valid) size_ff <= csr_tap_count;
   end
   assign csr_ready = 1'b1;

   skg_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .sts
   );

   skg_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .fraction(req_fraction), .tap_count(size_ff),
      .coefficient(rsp_coefficient), .tap_index(rsp_tap_index),
      .last_tap(rsp_last_tap)
   );

endmodule

// ----- sv/skg_datapath.sv -----
// Datapath for the sinc kernel generator: tap position, CORDIC sine,
// denominator multiply and radix-2 divider. Depends on skg_pkg.
module skg_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  skg_pkg::skg_cmd_type          cmd,
   output skg_pkg::skg_sts_type          sts,
   input  logic [skg_pkg::FRAC_W-1:0]    fraction,
   input  logic [skg_pkg::SIZE_W-1:0]    tap_count,
   output logic signed [skg_pkg::COEF_W-1:0] coefficient,
   output logic [skg_pkg::TAP_W-1:0]     tap_index,
   output logic                          last_tap
);

   logic [skg_pkg::FRAC_W-1:0] a_ff, a_in;
   logic [skg_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [skg_pkg::SIZE_W-1:0] tap_ff, tap_in;
   logic [skg_pkg::XR_W-1:0]   ax_ff, ax_in;
   logic                       odd_ff, odd_in;
   logic                       spec_ff, spec_in;
   logic                       zero_ff, zero_in;
   logic signed [skg_pkg::CW-1:0] cx_ff, cx_in, cy_ff, cy_in, z_ff, z_in;
   logic [skg_pkg::STEP_W-1:0] k_ff, k_in;
   logic [skg_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [skg_pkg::NUM_W-1:0]  rem_ff, rem_in, quo_ff, quo_in, num_ff, num_in;
   logic [skg_pkg::QCNT_W-1:0] qc_ff, qc_in;
   logic signed [skg_pkg::COEF_W-1:0] coef_ff, coef_in;
   logic [skg_pkg::TAP_W-1:0]  oidx_ff, oidx_in;
   logic                       olast_ff, olast_in;

   logic signed [skg_pkg::XR_W-1:0] x_raw;
   logic [skg_pkg::XR_W-1:0]   ax_c;
   logic [skg_pkg::FRAC_BITS-1:0] f_c, g_c;
   logic signed [skg_pkg::CW-1:0] dx, dy;
   logic [skg_pkg::NUM_W-1:0]  rem_sh;
   logic [71:0]                prod;
   logic [skg_pkg::SIZE_W-1:0] size_eff;

   // Form tap position: x = (2i - size + 2) * half - a
   always_comb begin
      x_raw = skg_pkg::XR_W'((skg_pkg::XR_W'(signed'({1'b0, tap_ff})) * 2
              - skg_pkg::XR_W'(size_ff) + 2)
              * (skg_pkg::XR_W'(1) << (skg_pkg::FRAC_BITS - 1))
              - skg_pkg::XR_W'(a_ff));
      ax_c  = x_raw[skg_pkg::XR_W-1] ? skg_pkg::XR_W'(-x_raw) : skg_pkg::XR_W'(x_raw);
      f_c   = ax_c[skg_pkg::FRAC_BITS-1:0];
      g_c   = (f_c <= (skg_pkg::FRAC_BITS'(1) << (skg_pkg::FRAC_BITS - 1))) ? f_c
              : skg_pkg::FRAC_BITS'(-f_c);
   end

   assign dx     = cy_ff >>> k_ff;
   assign dy     = cx_ff >>> k_ff;
   assign prod   = 72'(ax_ff) * 72'(skg_pkg::PI_Q30);
   assign rem_sh = {rem_ff[skg_pkg::NUM_W-2:0], num_ff[skg_pkg::NUM_W-1]};
   assign size_eff = (tap_count > skg_pkg::SIZE_W'(skg_pkg::MAX_TAPS))
                     ? skg_pkg::SIZE_W'(skg_pkg::MAX_TAPS) : tap_count;

   always_comb begin
      a_in = a_ff; size_in = size_ff; tap_in = tap_ff; ax_in = ax_ff;
      odd_in = odd_ff; spec_in = spec_ff; zero_in = zero_ff;
      cx_in = cx_ff; cy_in = cy_ff; z_in = z_ff; k_in = k_ff;
      den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff; num_in = num_ff;
      qc_in = qc_ff; coef_in = coef_ff; oidx_in = oidx_ff; olast_in = olast_ff;
      // Capture request, saturate fraction
      if (cmd.load) begin
         a_in    = (fraction > skg_pkg::ONE) ? skg_pkg::ONE : fraction;
         size_in = size_eff;
         tap_in  = '0;
      end
      // Latch position and seed CORDIC
      if (cmd.tap_setup) begin
         ax_in   = ax_c;
         odd_in  = ax_c[skg_pkg::FRAC_BITS];
         zero_in = (ax_c == '0);
         spec_in = (f_c == '0);
         cx_in   = skg_pkg::CORDIC_GAIN;
         cy_in   = '0;
         z_in    = skg_pkg::CW'(g_c) << (31 - skg_pkg::FRAC_BITS);
         k_in    = '0;
      end
      // One CORDIC rotation
      if (cmd.cordic_step) begin
         if (!z_ff[skg_pkg::CW-1]) begin
            cx_in = cx_ff - dx; cy_in = cy_ff + dy;
            z_in  = z_ff - skg_pkg::CW'(skg_pkg::atan_turn(k_ff));
         end else begin
            cx_in = cx_ff + dx; cy_in = cy_ff - dy;
            z_in  = z_ff + skg_pkg::CW'(skg_pkg::atan_turn(k_ff));
         end
         k_in = k_ff + 1'b1;
      end
      // Denominator pi*|x| in Q30
      if (cmd.den_mult) begin
         den_in = skg_pkg::DEN_W'(prod >> skg_pkg::FRAC_BITS);
         if (den_in == '0) den_in = skg_pkg::DEN_W'(1);
      end
      // Rounded numerator; divider starts
      if (cmd.div_init) begin
         num_in = (cy_ff[skg_pkg::CW-1] ? '0
                  : (skg_pkg::NUM_W'(cy_ff) << 16)) + skg_pkg::NUM_W'(den_ff >> 1);
         rem_in = '0;
         quo_in = '0;
         qc_in  = '0;
      end
      // One restoring division bit
      if (cmd.div_step) begin
         if (rem_sh >= skg_pkg::NUM_W'(den_ff)) begin
            rem_in = rem_sh - skg_pkg::NUM_W'(den_ff);
            quo_in = {quo_ff[skg_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[skg_pkg::NUM_W-2:0], 1'b0};
         end
         num_in = {num_ff[skg_pkg::NUM_W-2:0], 1'b0};
         qc_in  = qc_ff + 1'b1;
      end
      // Output register
      if (cmd.finish) begin
         if (zero_ff)
            coef_in = skg_pkg::COEF_ONE;
         else if (spec_ff)
            coef_in = '0;
         else begin
            coef_in = (quo_ff > skg_pkg::COEF_MAX) ? skg_pkg::COEF_W'(skg_pkg::COEF_MAX)
                      : skg_pkg::COEF_W'(quo_ff);
            if (odd_ff) coef_in = -coef_in;
         end
         oidx_in  = tap_ff[skg_pkg::TAP_W-1:0];
         olast_in = (tap_ff + 1'b1 == size_ff);
      end
      if (cmd.next_tap)
         tap_in = tap_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff  <= '0;
         qc_ff <= '0;
      end else begin
         k_ff  <= k_in;
         qc_ff <= qc_in;
      end
      a_ff <= a_in; size_ff <= size_in; tap_ff <= tap_in; ax_ff <= ax_in;
      odd_ff <= odd_in; spec_ff <= spec_in; zero_ff <= zero_in;
      cx_ff <= cx_in; cy_ff <= cy_in; z_ff <= z_in;
      den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in; num_ff <= num_in;
      coef_ff <= coef_in; oidx_ff <= oidx_in; olast_ff <= olast_in;
   end

   assign sts.size_zero   = (size_eff == '0);
   assign sts.special     = spec_ff;
   assign sts.last        = (tap_ff + 1'b1 == size_ff);
   assign sts.cordic_done = (k_ff == skg_pkg::STEP_W'(skg_pkg::CORDIC_STEPS - 1));
   assign sts.div_done    = (qc_ff == skg_pkg::QCNT_W'(skg_pkg::NUM_W - 1));
   assign coefficient = coef_ff;
   assign tap_index   = oidx_ff;
   assign last_tap    = olast_ff;

   // Divider never runs past its width
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && sts.div_done |=> qc_ff == '0 || !cmd.div_step)
      else $error("divider overrun");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish && !zero_ff && !spec_ff && odd_ff |=> coefficient <= 0)
      else $error("odd lobe not negative");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish && zero_ff |=> coefficient == skg_pkg::COEF_ONE)
      else $error("center tap not one");

endmodule

// ----- sv/skg_control.sv -----
// Controller state machine for the sinc kernel generator.
// Sequences the datapath per tap. Depends on skg_pkg.
module skg_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output skg_pkg::skg_cmd_type cmd,
   input  skg_pkg::skg_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE, S_SETUP, S_CORDIC, S_DEN, S_DINIT, S_DIV, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            if (!sts.size_zero) state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.tap_setup = 1'b1;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            // skip sine on integer positions
            if (sts.special) state_in = S_FIN;
            else begin
               cmd.cordic_step = 1'b1;
               if (sts.cordic_done) state_in = S_DEN;
            end
         end
         S_DEN: begin
            cmd.den_mult = 1'b1;
            state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            cmd.next_tap = 1'b1;
            last_in = sts.last;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_ready) state_in = last_ff ? S_IDLE : S_SETUP;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept during output");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && last_ff |=> req_ready) else $error("no return to idle");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.cordic_step, cmd.div_step, cmd.finish})) else $error("cmd overlap");

endmodule
